// File: design/prrs_pkg.sv
// Shared constants, codes and types of the priority round-robin scheduler.
package prrs_pkg;

   localparam int NUM_LEVELS = 16;
   localparam int TASK_SLOTS = 64;
   localparam int LEVEL_W    = $clog2(NUM_LEVELS);
   localparam int SLOT_W     = $clog2(TASK_SLOTS);

   localparam int ID_W     = 8;
   localparam int PRIO_W   = 4;
   localparam int BURST_W  = 16;
   localparam int SLICE_W  = 8;
   localparam int STATUS_W = 3;

   localparam int REQ_DATA_W = 32;
   localparam int RSP_DATA_W = 40;
   localparam int CSR_ADDR_W = 2;
   localparam int CSR_DATA_W = 8;

   localparam logic [CSR_ADDR_W-1:0] REG_QUANTUM = 2'd0;
   localparam logic [CSR_ADDR_W-1:0] REG_LOWEST  = 2'd1;
   localparam logic [CSR_ADDR_W-1:0] REG_HIGHEST = 2'd2;

   localparam logic [SLICE_W-1:0] QUANTUM_RESET = 8'd10;
   localparam logic [PRIO_W-1:0]  LOWEST_RESET  = 4'd1;
   localparam logic [PRIO_W-1:0]  HIGHEST_RESET = 4'd10;

   localparam logic KIND_ADD  = 1'b0;
   localparam logic KIND_NEXT = 1'b1;

   localparam logic [STATUS_W-1:0] STAT_ADDED    = 3'd0;
   localparam logic [STATUS_W-1:0] STAT_BAD_PRIO = 3'd1;
   localparam logic [STATUS_W-1:0] STAT_FULL     = 3'd2;
   localparam logic [STATUS_W-1:0] STAT_GRANTED  = 3'd3;
   localparam logic [STATUS_W-1:0] STAT_NONE     = 3'd4;

   typedef struct packed {
      logic               data_we;
      logic [SLOT_W-1:0]  data_addr;
      logic [ID_W-1:0]    id;
      logic [BURST_W-1:0] burst;
      logic               next_we;
      logic [SLOT_W-1:0]  next_addr;
      logic [SLOT_W-1:0]  next_val;
   } slot_wr_type;

endpackage

// File: design/prrs_slot_mem.sv
// Per-slot task memories: id, remaining burst and queue link.
module prrs_slot_mem (
   input  logic                          clock,
   input  logic                          rd_en,
   input  logic [prrs_pkg::SLOT_W-1:0]   rd_addr,
   input  prrs_pkg::slot_wr_type         wr,
   output logic [prrs_pkg::ID_W-1:0]     rd_id,
   output logic [prrs_pkg::BURST_W-1:0]  rd_burst,
   output logic [prrs_pkg::SLOT_W-1:0]   rd_next
);
   import prrs_pkg::*;

   logic [ID_W-1:0]    id_mem    [TASK_SLOTS];
   logic [BURST_W-1:0] burst_mem [TASK_SLOTS];
   logic [SLOT_W-1:0]  next_mem  [TASK_SLOTS];

   always_ff @(posedge clock) begin
      if (wr.data_we) begin
         id_mem[wr.data_addr]    <= wr.id;
         burst_mem[wr.data_addr] <= wr.burst;
      end
      if (wr.next_we) begin
         next_mem[wr.next_addr] <= wr.next_val;
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_id    <= id_mem[rd_addr];
         rd_burst <= burst_mem[rd_addr];
         rd_next  <= next_mem[rd_addr];
      end
   end

endmodule

// File: design/priority_round_robin_scheduler_top.sv
// Priority round-robin scheduler: per-level task queues kept in synchronous memories.
// Every request reads its level pointers on accept; an add is then answered from the level
// lookup, while a next first does the slot memory read-modify-write (it is answered from the
// level lookup when nothing waits). One request is in flight at a time; the next request is
// taken the cycle after the response is loaded, which waits until the output register is free.
// Reset: synchronous; all levels empty, all slots free, registers to defaults.
module priority_round_robin_scheduler_top (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_tvalid,
   output logic                                req_tready,
   input  logic [prrs_pkg::REQ_DATA_W-1:0]     req_tdata,  // task_id, priority_req, burst, pad
   input  logic                                req_tuser,  // kind
   output logic                                rsp_tvalid,
   input  logic                                rsp_tready,
   output logic [prrs_pkg::RSP_DATA_W-1:0]     rsp_tdata,  // served_id, served_level,
                                                           // slice_length, remaining_burst,
                                                           // task_finished, pad
   output logic [prrs_pkg::STATUS_W-1:0]       rsp_tuser,  // status
   input  logic                                csr_we,
   input  logic [prrs_pkg::CSR_ADDR_W-1:0]     csr_addr,
   input  logic [prrs_pkg::CSR_DATA_W-1:0]     csr_wdata
);
   import prrs_pkg::*;

   typedef enum logic [1:0] {ST_IDLE, ST_LEVEL, ST_SLOT} state_type;

   state_type state_ff, state_in;

   logic [SLICE_W-1:0] quantum_ff;
   logic [PRIO_W-1:0]  lowest_ff;
   logic [PRIO_W-1:0]  highest_ff;

   logic [NUM_LEVELS-1:0] nonempty_ff, nonempty_in;
   logic [TASK_SLOTS-1:0] free_ff, free_in;

   logic               kind_ff;
   logic [ID_W-1:0]    id_ff;
   logic [PRIO_W-1:0]  prio_ff;
   logic [BURST_W-1:0] burst_ff;
   logic [LEVEL_W-1:0] lvl_ff;
   logic               any_ff;

   logic [SLOT_W-1:0] level_head_mem [NUM_LEVELS];
   logic [SLOT_W-1:0] level_tail_mem [NUM_LEVELS];
   logic [SLOT_W-1:0] head_rd_ff;
   logic [SLOT_W-1:0] tail_rd_ff;
   logic              head_we, tail_we;
   logic [SLOT_W-1:0] head_wval, tail_wval;

   logic              rsp_valid_ff, rsp_valid_in;
   logic [STATUS_W-1:0] rsp_status_ff, rsp_status_in;
   logic [ID_W-1:0]     rsp_id_ff, rsp_id_in;
   logic [LEVEL_W-1:0]  rsp_level_ff, rsp_level_in;
   logic [SLICE_W-1:0]  rsp_slice_ff, rsp_slice_in;
   logic [BURST_W-1:0]  rsp_rem_ff, rsp_rem_in;
   logic                rsp_fin_ff, rsp_fin_in;
   logic                out_load;
   logic                out_free;

   logic                req_fire;
   logic [LEVEL_W-1:0]  hi_lvl;
   logic                hi_any;
   logic [LEVEL_W-1:0]  lvl_sel;
   logic [SLOT_W-1:0]   free_slot;
   logic                free_any;

   slot_wr_type        slot_wr;
   logic               slot_rd_en;
   logic [ID_W-1:0]    slot_rd_id;
   logic [BURST_W-1:0] slot_rd_burst;
   logic [SLOT_W-1:0]  slot_rd_next;

   prrs_slot_mem u_slot_mem (
      .clock    (clock),
      .rd_en    (slot_rd_en),
      .rd_addr  (head_rd_ff),
      .wr       (slot_wr),
      .rd_id    (slot_rd_id),
      .rd_burst (slot_rd_burst),
      .rd_next  (slot_rd_next)
   );

   assign req_tready = (state_ff == ST_IDLE);
   assign req_fire   = req_tvalid && req_tready;
   assign out_free   = !rsp_valid_ff || rsp_tready;

   always_comb begin
      hi_lvl = '0;
      hi_any = 1'b0;
      for (int l = 0; l < NUM_LEVELS; l++) begin
         if (nonempty_ff[l]) begin
            hi_lvl = LEVEL_W'(l);
            hi_any = 1'b1;
         end
      end
   end

   always_comb begin
      free_slot = '0;
      free_any  = 1'b0;
      for (int s = TASK_SLOTS - 1; s >= 0; s--) begin
         if (free_ff[s]) begin
            free_slot = SLOT_W'(s);
            free_any  = 1'b1;
         end
      end
   end

   assign lvl_sel = (req_tuser == KIND_NEXT) ? hi_lvl : LEVEL_W'(req_tdata[11:8]);

   always_ff @(posedge clock) begin
      if (head_we) begin
         level_head_mem[lvl_ff] <= head_wval;
      end
      if (tail_we) begin
         level_tail_mem[lvl_ff] <= tail_wval;
      end
   end

   always_ff @(posedge clock) begin
      if (req_fire) begin
         head_rd_ff <= level_head_mem[lvl_sel];
         tail_rd_ff <= level_tail_mem[lvl_sel];
      end
   end

   always_comb begin
      logic               bad;
      logic [SLICE_W-1:0] slice;
      logic [BURST_W-1:0] rem;
      logic               fin;

      bad   = (prio_ff < lowest_ff) || (prio_ff > highest_ff) ||
              (int'(prio_ff) >= NUM_LEVELS);
      fin   = !({8'd0, quantum_ff} < slot_rd_burst);
      slice = fin ? slot_rd_burst[SLICE_W-1:0] : quantum_ff;
      rem   = slot_rd_burst - {8'd0, slice};

      state_in      = state_ff;
      nonempty_in   = nonempty_ff;
      free_in       = free_ff;
      out_load      = 1'b0;
      rsp_status_in = STAT_ADDED;
      rsp_id_in     = '0;
      rsp_level_in  = '0;
      rsp_slice_in  = '0;
      rsp_rem_in    = '0;
      rsp_fin_in    = 1'b0;
      head_we       = 1'b0;
      tail_we       = 1'b0;
      head_wval     = '0;
      tail_wval     = '0;
      slot_rd_en    = 1'b0;
      slot_wr       = '0;

      case (state_ff)
         ST_IDLE: begin
            if (req_fire) begin
               state_in = ST_LEVEL;
            end
         end
         ST_LEVEL: begin
            if (kind_ff == KIND_ADD) begin
               if (out_free) begin
                  out_load = 1'b1;
                  state_in = ST_IDLE;
                  if (bad) begin
                     rsp_status_in = STAT_BAD_PRIO;
                  end else if (!free_any) begin
                     rsp_status_in = STAT_FULL;
                  end else begin
                     rsp_status_in      = STAT_ADDED;
                     free_in[free_slot] = 1'b0;
                     slot_wr.data_we    = 1'b1;
                     slot_wr.data_addr  = free_slot;
                     slot_wr.id         = id_ff;
                     slot_wr.burst      = burst_ff;
                     tail_we            = 1'b1;
                     tail_wval          = free_slot;
                     if (nonempty_ff[lvl_ff]) begin
                        slot_wr.next_we   = 1'b1;
                        slot_wr.next_addr = tail_rd_ff;
                        slot_wr.next_val  = free_slot;
                     end else begin
                        head_we             = 1'b1;
                        head_wval           = free_slot;
                        nonempty_in[lvl_ff] = 1'b1;
                     end
                  end
               end
            end else if (!any_ff) begin
               if (out_free) begin
                  out_load      = 1'b1;
                  rsp_status_in = STAT_NONE;
                  state_in      = ST_IDLE;
               end
            end else begin
               slot_rd_en = 1'b1;
               state_in   = ST_SLOT;
            end
         end
         ST_SLOT: begin
            if (out_free) begin
               out_load      = 1'b1;
               state_in      = ST_IDLE;
               rsp_status_in = STAT_GRANTED;
               rsp_id_in     = slot_rd_id;
               rsp_level_in  = lvl_ff;
               rsp_slice_in  = slice;
               if (fin) begin
                  rsp_fin_in          = 1'b1;
                  free_in[head_rd_ff] = 1'b1;
                  if (tail_rd_ff == head_rd_ff) begin
                     nonempty_in[lvl_ff] = 1'b0;
                  end else begin
                     head_we   = 1'b1;
                     head_wval = slot_rd_next;
                  end
               end else begin
                  rsp_rem_in        = rem;
                  slot_wr.data_we   = 1'b1;
                  slot_wr.data_addr = head_rd_ff;
                  slot_wr.id        = slot_rd_id;
                  slot_wr.burst     = rem;
                  if (tail_rd_ff != head_rd_ff) begin
                     head_we           = 1'b1;
                     head_wval         = slot_rd_next;
                     tail_we           = 1'b1;
                     tail_wval         = head_rd_ff;
                     slot_wr.next_we   = 1'b1;
                     slot_wr.next_addr = tail_rd_ff;
                     slot_wr.next_val  = head_rd_ff;
                  end
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   assign rsp_valid_in = out_load || (rsp_valid_ff && !rsp_tready);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         nonempty_ff  <= '0;
         free_ff      <= '1;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         nonempty_ff  <= nonempty_in;
         free_ff      <= free_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      if (req_fire) begin
         kind_ff  <= req_tuser;
         id_ff    <= req_tdata[7:0];
         prio_ff  <= req_tdata[11:8];
         burst_ff <= req_tdata[27:12];
         lvl_ff   <= lvl_sel;
         any_ff   <= hi_any;
      end
      if (out_load) begin
         rsp_status_ff <= rsp_status_in;
         rsp_id_ff     <= rsp_id_in;
         rsp_level_ff  <= rsp_level_in;
         rsp_slice_ff  <= rsp_slice_in;
         rsp_rem_ff    <= rsp_rem_in;
         rsp_fin_ff    <= rsp_fin_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         quantum_ff <= QUANTUM_RESET;
         lowest_ff  <= LOWEST_RESET;
         highest_ff <= HIGHEST_RESET;
      end else if (csr_we) begin
         case (csr_addr)
            REG_QUANTUM: quantum_ff <= csr_wdata[SLICE_W-1:0];
            REG_LOWEST:  lowest_ff  <= csr_wdata[PRIO_W-1:0];
            REG_HIGHEST: highest_ff <= csr_wdata[PRIO_W-1:0];
            default: begin
            end
         endcase
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tuser  = rsp_status_ff;
   assign rsp_tdata  = {3'd0, rsp_fin_ff, rsp_rem_ff, rsp_slice_ff,
                        PRIO_W'(rsp_level_ff), rsp_id_ff};

   a_accept_to_level: assert property (@(posedge clock) disable iff (reset)
      req_fire |=> state_ff == ST_LEVEL)
      else $error("accepted request did not start the level lookup");

   a_slot_after_level: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_SLOT |-> $past(state_ff) == ST_LEVEL || $past(state_ff) == ST_SLOT)
      else $error("slot stage entered without a level lookup");

   a_levels_hold_tasks: assert property (@(posedge clock) disable iff (reset)
      $countones(~free_ff) >= $countones(nonempty_ff))
      else $error("nonempty level count exceeds occupied slots");

endmodule
